@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled while rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PDFSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PDFSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/pdfsp_pkg.sv @@
// ----------------------------------------------------------------------------
// pdfsp_pkg
// Widths, codes and unit handshake types of the PWM duty and sample player.
// ----------------------------------------------------------------------------
package pdfsp_pkg;

  localparam int PERIOD_W  = 27;
  localparam int VALUE_W   = 32;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 3;
  localparam int BYTE_W    = 8;
  localparam int PCT_W     = 7;

  // Serial arithmetic units
  localparam int MUL_W     = PERIOD_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIVISOR_W = PERIOD_W + 1;
  localparam int STEP_W    = $clog2(PROD_W + 1);

  localparam int DEF_SAMPLE_DEPTH = 4096;
  localparam int DEF_AUDIO_PERIOD = 255;

  localparam logic [PERIOD_W-1:0] RESET_PERIOD      = 27'd255;
  localparam logic [PERIOD_W-1:0] RESET_DUTY        = 27'd127;
  localparam logic [PERIOD_W-1:0] RESET_TIMER_CLOCK = 27'd10000000;
  localparam logic [PCT_W-1:0]    PCT_MAX           = 7'd100;

  typedef enum logic [OP_W-1:0] {
    OP_SET_DUTY = 3'd0,
    OP_SET_FREQ = 3'd1,
    OP_LOAD     = 3'd2,
    OP_START    = 3'd3,
    OP_STOP     = 3'd4,
    OP_TICK     = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_BUSY        = 3'd2,
    ST_NO_SAMPLES  = 3'd3,
    ST_FULL        = 3'd4,
    ST_UNSUPPORTED = 3'd5
  } status_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [PROD_W-1:0]    dividend;
    logic [DIVISOR_W-1:0] divisor;
    logic [STEP_W-1:0]    steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hdl/pdfsp_mul.sv @@
// ----------------------------------------------------------------------------
// pdfsp_mul
// Shift-add multiplier retiring one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pdfsp_mul import pdfsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CNT_W = $clog2(MUL_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [MUL_W-1:0] a_reg;
  logic [MUL_W-1:0] hi;
  logic [MUL_W-1:0] lo;
  logic [MUL_W:0]   sum;

  assign sum = {1'b0, hi} + {1'b0, (lo[0] ? a_reg : '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a_reg <= req.a;
        hi    <= '0;
        lo    <= req.b;
        cnt   <= CNT_W'(MUL_W);
        busy  <= 1'b1;
      end else if (busy) begin
        // add on the low bit, then shift the partial product right
        hi  <= sum[MUL_W:1];
        lo  <= {sum[0], lo[MUL_W-1:1]};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.product = {hi, lo};

endmodule

@@ hdl/pdfsp_div.sv @@
// ----------------------------------------------------------------------------
// pdfsp_div
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdfsp_div import pdfsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [STEP_W-1:0]    cnt;
  logic [DIVISOR_W-1:0] d_reg;
  logic [DIVISOR_W-1:0] rem;
  logic [PROD_W-1:0]    quo;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  // dividend enters left-aligned; its bits shift out as quotient bits shift in
  assign shifted = {rem, quo[PROD_W-1]};
  assign ge      = shifted >= {1'b0, d_reg};
  assign diff    = shifted - {1'b0, d_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        d_reg <= req.divisor;
        rem   <= '0;
        quo   <= req.dividend;
        cnt   <= req.steps;
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quo <= {quo[PROD_W-2:0], ge};
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ hdl/pdfsp_smem.sv @@
// ----------------------------------------------------------------------------
// pdfsp_smem
// Sample byte memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pdfsp_smem import pdfsp_pkg::*; #(
  parameter int DEPTH  = DEF_SAMPLE_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/pwm_duty_freq_and_sample_player.sv @@
// Command flow: set_duty and set_freq run bit-serial multiply and divide passes; tick makes
//   one sample memory read; every other command goes straight to the result word.
// Throughput: one command word in flight; the next is taken once the result enters the
//   output register, which holds it while the consumer stalls.
// Reset (synchronous, rst high): period 255, duty 127, no samples, idle, timer clock
//   10000000 Hz; sample memory content is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
// pwm_duty_freq_and_sample_player
// PWM period/duty controller with 8-bit sample playback through the duty value.
// ----------------------------------------------------------------------------
module pwm_duty_freq_and_sample_player import pdfsp_pkg::*; #(
  parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH,
  parameter int AUDIO_PERIOD = DEF_AUDIO_PERIOD
) (
  input  logic                clk,
  input  logic                rst,
  // command words
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  logic [OP_W-1:0]     operation,
  input  logic [VALUE_W-1:0]  value,
  input  logic [BYTE_W-1:0]   sample_byte,
  input  logic                first_of_batch,
  // result words
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [VALUE_W-1:0]  reply_value,
  output logic [PERIOD_W-1:0] pwm_period,
  output logic [PERIOD_W-1:0] pwm_duty,
  output logic                is_playing,
  // timer clock register
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data
);

  localparam int CW = $clog2(SAMPLE_DEPTH + 1);   // sample count, may equal the depth
  localparam int AW = $clog2(SAMPLE_DEPTH);       // memory address
  localparam logic [PERIOD_W-1:0] AUDIO_P  = PERIOD_W'(AUDIO_PERIOD);
  localparam logic [PERIOD_W-1:0] MID_DUTY = PERIOD_W'(AUDIO_PERIOD / 2);
  localparam logic [CW-1:0]       DEPTH_C  = CW'(SAMPLE_DEPTH);
  // (period + 1) * percent fits in this many bits; left-align it for the divider
  localparam int DUTY_PROD_W = MUL_W + PCT_W;
  localparam int DUTY_SHIFT  = PROD_W - DUTY_PROD_W;

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_DUTY_MUL   = 8'b0000_0010,
    S_DUTY_DIV   = 8'b0000_0100,
    S_FREQ_DIV   = 8'b0000_1000,
    S_FREQ_MUL   = 8'b0001_0000,
    S_FREQ_SCALE = 8'b0010_0000,
    S_READ       = 8'b0100_0000,
    S_FINISH     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // Architectural state
  logic [PERIOD_W-1:0] period_ticks;
  logic [PERIOD_W-1:0] duty_ticks;
  logic [PERIOD_W-1:0] timer_clock;
  logic [CW-1:0]       sample_count;
  logic [CW-1:0]       play_index;
  logic                playing;

  // Per-command working registers
  logic [PERIOD_W-1:0] np_reg;
  status_t             res_status;
  logic [VALUE_W-1:0]  res_reply;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              cmd_accept;
  logic              out_free;
  logic [PCT_W-1:0]  pct_in;
  logic              freq_bad;
  logic [CW-1:0]     load_base;
  logic [CW-1:0]     load_count;
  logic              load_full;
  logic              tick_go;
  logic [PERIOD_W-1:0] freq_np;
  logic              wr_en;
  logic [BYTE_W-1:0] rd_data;

  // Lower clamp to 1 first, then upper clamp to the limit: a zero limit wins.
  function automatic logic [PERIOD_W-1:0] clamp_duty(input logic [PROD_W-1:0]   q,
                                                     input logic [PERIOD_W-1:0] lim);
    logic [PROD_W-1:0] d;
    d = (q == '0) ? PROD_W'(1) : q;
    if (d > PROD_W'(lim)) begin
      d = PROD_W'(lim);
    end
    return d[PERIOD_W-1:0];
  endfunction

  assign cmd_stall  = (state != S_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign cfg_ready  = (state == S_IDLE);
  assign out_free   = !rsp_valid || !rsp_stall;

  assign pct_in     = (value > VALUE_W'(PCT_MAX)) ? PCT_MAX : value[PCT_W-1:0];
  assign freq_bad   = (value == '0) || (value > VALUE_W'(timer_clock));
  // first word of a batch discards what was loaded before
  assign load_base  = first_of_batch ? '0 : sample_count;
  assign load_count = load_base + CW'(1);
  assign load_full  = !first_of_batch && (sample_count >= DEPTH_C);
  assign tick_go    = playing && (play_index < sample_count) && (play_index < DEPTH_C);
  assign freq_np    = div_rsp.quotient[PERIOD_W-1:0] - PERIOD_W'(1);

  // Sequencer: pick the next step and launch the serial units
  always_comb begin
    state_next = state;
    mul_req    = '0;
    div_req    = '0;
    wr_en      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_accept) begin
          state_next = S_FINISH;
          unique case (op_t'(operation))
            OP_SET_DUTY: begin
              if (pct_in != '0) begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_W'(period_ticks) + MUL_W'(1);
                mul_req.b     = MUL_W'(pct_in);
                state_next    = S_DUTY_MUL;
              end
            end
            OP_SET_FREQ: begin
              if (!freq_bad) begin
                // new period + 1 = timer clock / frequency
                div_req.start    = 1'b1;
                div_req.dividend = {timer_clock, (PROD_W - PERIOD_W)'(0)};
                div_req.divisor  = DIVISOR_W'(value[PERIOD_W-1:0]);
                div_req.steps    = STEP_W'(PERIOD_W);
                state_next       = S_FREQ_DIV;
              end
            end
            OP_LOAD: begin
              wr_en = !playing && !load_full;
            end
            OP_TICK: begin
              if (tick_go) begin
                state_next = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUTY_MUL: begin
        if (mul_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = mul_rsp.product << DUTY_SHIFT;
          div_req.divisor  = DIVISOR_W'(PCT_MAX);
          div_req.steps    = STEP_W'(DUTY_PROD_W);
          state_next       = S_DUTY_DIV;
        end
      end
      S_DUTY_DIV: begin
        if (div_rsp.done) begin
          state_next = S_FINISH;
        end
      end
      S_FREQ_DIV: begin
        if (div_rsp.done) begin
          if (period_ticks != '0) begin
            // rescale: duty * (new period + 1) / (old period + 1)
            mul_req.start = 1'b1;
            mul_req.a     = div_rsp.quotient[MUL_W-1:0];
            mul_req.b     = MUL_W'(duty_ticks);
            state_next    = S_FREQ_MUL;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_FREQ_MUL: begin
        if (mul_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = mul_rsp.product;
          div_req.divisor  = DIVISOR_W'(period_ticks) + DIVISOR_W'(1);
          div_req.steps    = STEP_W'(PROD_W);
          state_next       = S_FREQ_SCALE;
        end
      end
      S_FREQ_SCALE: begin
        if (div_rsp.done) begin
          state_next = S_FINISH;
        end
      end
      S_READ: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      period_ticks <= RESET_PERIOD;
      duty_ticks   <= RESET_DUTY;
      timer_clock  <= RESET_TIMER_CLOCK;
      sample_count <= '0;
      play_index   <= '0;
      playing      <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        timer_clock <= cfg_data;
      end

      // drop the result word once taken
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            res_status <= ST_OK;
            res_reply  <= '0;
            unique case (op_t'(operation))
              OP_SET_DUTY: begin
                res_reply <= VALUE_W'(pct_in);
                if (pct_in == '0) begin
                  duty_ticks <= clamp_duty(PROD_W'(1), period_ticks);
                end
              end
              OP_SET_FREQ: begin
                if (freq_bad) begin
                  res_status <= ST_INVALID;
                end else begin
                  res_reply <= value;
                end
              end
              OP_LOAD: begin
                if (playing) begin
                  res_status <= ST_BUSY;
                end else if (load_full) begin
                  res_status <= ST_FULL;
                end else begin
                  sample_count <= load_count;
                  res_reply    <= VALUE_W'(load_count);
                end
              end
              OP_START: begin
                if (sample_count == '0) begin
                  res_status <= ST_NO_SAMPLES;
                end else if (playing) begin
                  res_status <= ST_BUSY;
                end else begin
                  period_ticks <= AUDIO_P;
                  duty_ticks   <= MID_DUTY;
                  play_index   <= '0;
                  playing      <= 1'b1;
                  res_reply    <= VALUE_W'(sample_count);
                end
              end
              OP_STOP: begin
                playing    <= 1'b0;
                duty_ticks <= MID_DUTY;
              end
              OP_TICK: begin
                // past the last sample: return to mid-scale and end playback
                if (playing && !tick_go) begin
                  duty_ticks <= MID_DUTY;
                  playing    <= 1'b0;
                end
              end
              default: res_status <= ST_UNSUPPORTED;
            endcase
          end
        end
        S_DUTY_DIV: begin
          if (div_rsp.done) begin
            duty_ticks <= clamp_duty(div_rsp.quotient, period_ticks);
          end
        end
        S_FREQ_DIV: begin
          if (div_rsp.done) begin
            np_reg <= freq_np;
            // from a zero period the duty restarts at one tick, clamped to the new period
            if (period_ticks == '0) begin
              duty_ticks   <= clamp_duty(PROD_W'(1), freq_np);
              period_ticks <= freq_np;
            end
          end
        end
        S_FREQ_SCALE: begin
          if (div_rsp.done) begin
            duty_ticks   <= clamp_duty(div_rsp.quotient, np_reg);
            period_ticks <= np_reg;
          end
        end
        S_READ: begin
          // sample drives the compare value unclamped
          duty_ticks <= PERIOD_W'(rd_data);
          play_index <= play_index + CW'(1);
        end
        S_FINISH: begin
          if (out_free) begin
            rsp_valid   <= 1'b1;
            status      <= res_status;
            reply_value <= res_reply;
            pwm_period  <= period_ticks;
            pwm_duty    <= duty_ticks;
            is_playing  <= playing;
          end
        end
        default: ;
      endcase
    end
  end

  pdfsp_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  pdfsp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Read port follows the play index; its registered data is taken up in S_READ, after a tick is taken
  pdfsp_smem #(
    .DEPTH  (SAMPLE_DEPTH),
    .ADDR_W (AW)
  ) u_smem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (load_base[AW-1:0]),
    .wr_data (sample_byte),
    .rd_addr (play_index[AW-1:0]),
    .rd_data (rd_data)
  );

endmodule

@@ hdl/pdfsp_checker.sv @@
// ----------------------------------------------------------------------------
// pdfsp_checker
// Port-level checks of the PWM duty and sample player, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdfsp_checker import pdfsp_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_stall,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input logic [STATUS_W-1:0] status,
  input logic [VALUE_W-1:0]  reply_value,
  input logic [PERIOD_W-1:0] pwm_period,
  input logic [PERIOD_W-1:0] pwm_duty,
  input logic                is_playing
);

  // hold a stalled result word
  `PDFSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(reply_value) && $stable(pwm_period) && $stable(pwm_duty) && $stable(is_playing), "result word changed while stalled")

  // one command in flight: stall right after a word is taken
  `PDFSP_ASSERT_NEXT(a_one_in_flight, cmd_valid && !cmd_stall, cmd_stall, "second command taken while busy")

  `PDFSP_ASSERT_NOW(a_err_reply_zero, rsp_valid && status != ST_OK, reply_value == '0, "error result with nonzero reply")

  `PDFSP_ASSERT_NOW(a_busy_playing, rsp_valid && status == ST_BUSY, is_playing, "busy reported while not playing")

endmodule

bind pwm_duty_freq_and_sample_player pdfsp_checker u_pdfsp_checker (.*);
